@@ src/resp_command_stream_parser_macros.svh @@
// assertion helpers shared by the checker
`ifndef RESP_COMMAND_STREAM_PARSER_MACROS_SVH
`define RESP_COMMAND_STREAM_PARSER_MACROS_SVH

// same-cycle implication, off during reset
`define RCSP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcsp assertion failed");

// next-cycle implication, off during reset
`define RCSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcsp assertion failed");

`endif

@@ src/rcsp_pkg.sv @@
package rcsp_pkg;

   // build-time defaults
   localparam int unsigned MAX_ARGS_DEF = 64;
   localparam int unsigned LEN_BITS_DEF = 31;

   // field widths
   localparam int unsigned LIMIT_BITS = 7;
   localparam int unsigned BULK_BITS  = 31;
   localparam int unsigned INDEX_BITS = 6;

   // register reset values
   localparam logic [LIMIT_BITS-1:0] ARG_LIMIT_RST = 7'd64;
   localparam logic [BULK_BITS-1:0]  MAX_BULK_RST  = 31'h4000_0000;

   // characters
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   typedef enum logic [0:0] {
      CSR_ARG_LIMIT    = 1'b0,
      CSR_MAX_BULK_LEN = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_HDR_PREFIX = 3'd0,
      PH_HDR_LINE   = 3'd1,
      PH_LEN_PREFIX = 3'd2,
      PH_LEN_LINE   = 3'd3,
      PH_DATA       = 3'd4,
      PH_DATA_CR    = 3'd5,
      PH_DATA_LF    = 3'd6,
      PH_ERROR      = 3'd7
   } phase_type;

   typedef struct packed {
      logic negative;
      logic started;
      logic ended;
   } num_flags_type;

   typedef struct packed {
      logic                  payload_valid;
      logic [7:0]            payload_byte;
      logic [INDEX_BITS-1:0] arg_index;
      logic                  arg_done;
      logic [BULK_BITS-1:0]  arg_length;
      logic                  cmd_done;
      logic [LIMIT_BITS-1:0] arg_count;
      logic                  fault;
   } result_type;

endpackage

@@ src/rcsp_num.sv @@
module rcsp_num #(
   parameter int unsigned LEN_BITS = 31
) (
   input  logic [7:0]                 data_byte,
   input  rcsp_pkg::num_flags_type    flags_cur,
   input  logic [LEN_BITS-1:0]        acc_cur,
   output rcsp_pkg::num_flags_type    flags_nxt,
   output logic [LEN_BITS-1:0]        acc_nxt,
   output logic                       overflow
);
   import rcsp_pkg::*;

   localparam logic [LEN_BITS+3:0] TOP = {4'b0, {LEN_BITS{1'b1}}};

   logic              is_digit;
   logic              is_space;
   logic [3:0]        digit_full;
   logic [LEN_BITS+3:0] acc_wide;
   logic [LEN_BITS+3:0] acc_times_ten;

   assign is_digit   = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
   assign is_space   = (data_byte == CHAR_SPACE) ||
                       ((data_byte >= CHAR_TAB) && (data_byte <= CHAR_CR));
   assign digit_full = 4'(data_byte - CHAR_ZERO);
   assign acc_wide   = {4'b0, acc_cur};
   // times ten plus the digit, as two shifts and two adds
   assign acc_times_ten = (acc_wide << 3) + (acc_wide << 1) +
                          {{LEN_BITS{1'b0}}, digit_full};

   always_comb begin
      flags_nxt = flags_cur;
      acc_nxt   = acc_cur;
      overflow  = 1'b0;
      if (flags_cur.ended) begin
         // rest of the line ignored
      end else if (is_digit) begin
         flags_nxt.started = 1'b1;
         if (acc_times_ten > TOP) begin
            acc_nxt  = TOP[LEN_BITS-1:0];
            overflow = 1'b1;
         end else begin
            acc_nxt = acc_times_ten[LEN_BITS-1:0];
         end
      end else if (!flags_cur.started && is_space) begin
         // leading white space skipped
      end else if (!flags_cur.started &&
                   (data_byte == CHAR_PLUS || data_byte == CHAR_MINUS)) begin
         flags_nxt.started  = 1'b1;
         flags_nxt.negative = (data_byte == CHAR_MINUS);
      end else begin
         flags_nxt.ended = 1'b1;
      end
   end

endmodule

@@ src/rcsp_parser.sv @@
module rcsp_parser #(
   parameter int unsigned MAX_ARGS = 64,
   parameter int unsigned LEN_BITS = 31
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic                                op,
   input  logic [7:0]                          data_byte,
   input  logic [rcsp_pkg::LIMIT_BITS-1:0]     arg_limit,
   input  logic [rcsp_pkg::BULK_BITS-1:0]      max_bulk_len,
   output rcsp_pkg::result_type                result
);
   import rcsp_pkg::*;

   phase_type             phase_ff, phase_in;
   logic                  prev_cr_ff, prev_cr_in;
   logic [LEN_BITS-1:0]   acc_ff, acc_in;
   num_flags_type         flags_ff, flags_in;
   logic [LIMIT_BITS-1:0] expected_ff, expected_in;
   logic [LIMIT_BITS-1:0] received_ff, received_in;
   logic [LEN_BITS-1:0]   bytes_left_ff, bytes_left_in;
   logic [LEN_BITS-1:0]   cur_len_ff, cur_len_in;

   num_flags_type         num_flags;
   logic [LEN_BITS-1:0]   num_acc;
   logic                  num_ovf;

   logic [8:0]            lim;
   logic                  bad_sign;
   logic [LIMIT_BITS-1:0] received_inc;
   logic [LEN_BITS-1:0]   bytes_dec;
   logic [BULK_BITS-1:0]  cur_len_ext;
   logic                  det_fault;

   rcsp_num #(.LEN_BITS(LEN_BITS)) u_num (
      .data_byte (data_byte),
      .flags_cur (flags_ff),
      .acc_cur   (acc_ff),
      .flags_nxt (num_flags),
      .acc_nxt   (num_acc),
      .overflow  (num_ovf)
   );

   assign lim = (9'(arg_limit) < 9'(MAX_ARGS)) ? 9'(arg_limit) : 9'(MAX_ARGS);
   assign bad_sign     = flags_ff.negative && (acc_ff != '0);
   assign received_inc = received_ff + 1'b1;
   assign bytes_dec    = (bytes_left_ff != '0) ? bytes_left_ff - 1'b1 : bytes_left_ff;
   assign cur_len_ext  = BULK_BITS'(cur_len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HDR_PREFIX;
         prev_cr_ff    <= 1'b0;
         acc_ff        <= '0;
         flags_ff      <= '0;
         expected_ff   <= '0;
         received_ff   <= '0;
         bytes_left_ff <= '0;
         cur_len_ff    <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         prev_cr_ff    <= prev_cr_in;
         acc_ff        <= acc_in;
         flags_ff      <= flags_in;
         expected_ff   <= expected_in;
         received_ff   <= received_in;
         bytes_left_ff <= bytes_left_in;
         cur_len_ff    <= cur_len_in;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      prev_cr_in    = prev_cr_ff;
      acc_in        = acc_ff;
      flags_in      = flags_ff;
      expected_in   = expected_ff;
      received_in   = received_ff;
      bytes_left_in = bytes_left_ff;
      cur_len_in    = cur_len_ff;
      result        = '0;
      det_fault     = 1'b0;

      if (op) begin
         phase_in      = PH_HDR_PREFIX;
         prev_cr_in    = 1'b0;
         acc_in        = '0;
         flags_in      = '0;
         expected_in   = '0;
         received_in   = '0;
         bytes_left_in = '0;
         cur_len_in    = '0;
      end else if (phase_ff == PH_ERROR) begin
         result.fault = 1'b1;
      end else begin
         result.arg_index = received_ff[INDEX_BITS-1:0];
         unique case (phase_ff) inside
            PH_HDR_PREFIX, PH_LEN_PREFIX: begin
               if (data_byte != ((phase_ff == PH_HDR_PREFIX) ? CHAR_STAR : CHAR_DOLLAR)) begin
                  det_fault = 1'b1;
               end else begin
                  prev_cr_in = 1'b0;
                  acc_in     = '0;
                  flags_in   = '0;
                  phase_in   = (phase_ff == PH_HDR_PREFIX) ? PH_HDR_LINE : PH_LEN_LINE;
               end
            end
            PH_HDR_LINE, PH_LEN_LINE: begin
               if (data_byte == CHAR_LF) begin
                  if (!prev_cr_ff) begin
                     det_fault = 1'b1;
                  end else if (phase_ff == PH_HDR_LINE) begin
                     if (bad_sign || acc_ff == '0 || 32'(acc_ff) > 32'(lim)) begin
                        det_fault = 1'b1;
                     end else begin
                        // count is at most the limit, so seven bits hold it
                        expected_in = acc_ff[LIMIT_BITS-1:0];
                        received_in = '0;
                        phase_in    = PH_LEN_PREFIX;
                     end
                  end else begin
                     if (bad_sign || 32'(acc_ff) > 32'(max_bulk_len)) begin
                        det_fault = 1'b1;
                     end else begin
                        cur_len_in    = acc_ff;
                        bytes_left_in = acc_ff;
                        phase_in      = (acc_ff == '0) ? PH_DATA_CR : PH_DATA;
                     end
                  end
               end else begin
                  prev_cr_in = (data_byte == CHAR_CR);
                  flags_in   = num_flags;
                  acc_in     = num_acc;
                  det_fault  = num_ovf;
               end
            end
            PH_DATA: begin
               result.payload_valid = 1'b1;
               result.payload_byte  = data_byte;
               bytes_left_in        = bytes_dec;
               if (bytes_dec == '0) begin
                  phase_in = PH_DATA_CR;
               end
            end
            PH_DATA_CR: begin
               if (data_byte != CHAR_CR) begin
                  det_fault = 1'b1;
               end else begin
                  phase_in = PH_DATA_LF;
               end
            end
            PH_DATA_LF: begin
               if (data_byte != CHAR_LF) begin
                  det_fault = 1'b1;
               end else begin
                  result.arg_done   = 1'b1;
                  result.arg_length = cur_len_ext;
                  received_in       = received_inc;
                  if (received_inc >= expected_ff) begin
                     result.cmd_done  = 1'b1;
                     result.arg_count = expected_ff;
                     phase_in         = PH_HDR_PREFIX;
                     prev_cr_in       = 1'b0;
                     acc_in           = '0;
                     flags_in         = '0;
                     expected_in      = '0;
                     received_in      = '0;
                     bytes_left_in    = '0;
                     cur_len_in       = '0;
                  end else begin
                     phase_in = PH_LEN_PREFIX;
                  end
               end
            end
            default: begin
               det_fault = 1'b1;
            end
         endcase
         if (det_fault) begin
            phase_in     = PH_ERROR;
            result       = '0;
            result.fault = 1'b1;
         end
      end
   end

endmodule

@@ src/resp_command_stream_parser.sv @@
// channel   dir   words                          handshake
// req_      in    op, data_byte                  req_valid / req_ready
// rsp_      out   one result word per req word   rsp_valid / rsp_ready
// csr_      in    arg_limit, max_bulk_len        csr_wr_en, no wait
//
// one word per cycle sustained while rsp is not stalled; an accepted word reaches rsp
// through the input register, then the parse logic into the result register
// the parse state is updated in the same cycle the word moves into the result register
// reset clears parse state and the error phase and returns both csr registers to their
// reset values
// a stall on rsp holds the result register; req keeps flowing until the input
// register is also full
module resp_command_stream_parser #(
   parameter int unsigned MAX_ARGS = rcsp_pkg::MAX_ARGS_DEF,
   parameter int unsigned LEN_BITS = rcsp_pkg::LEN_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request words
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic [7:0]                          req_data_byte,
   // result words
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_payload_valid,
   output logic [7:0]                          rsp_payload_byte,
   output logic [rcsp_pkg::INDEX_BITS-1:0]     rsp_arg_index,
   output logic                                rsp_arg_done,
   output logic [rcsp_pkg::BULK_BITS-1:0]      rsp_arg_length,
   output logic                                rsp_cmd_done,
   output logic [rcsp_pkg::LIMIT_BITS-1:0]     rsp_arg_count,
   output logic                                rsp_fault,
   // register writes
   input  logic                                csr_wr_en,
   input  rcsp_pkg::csr_index_type             csr_index,
   input  logic [rcsp_pkg::BULK_BITS-1:0]      csr_wdata
);
   import rcsp_pkg::*;

   // configuration registers
   logic [LIMIT_BITS-1:0] arg_limit_ff;
   logic [BULK_BITS-1:0]  max_bulk_ff;

   // input register
   logic       in_valid_ff;
   logic       in_op_ff;
   logic [7:0] in_byte_ff;

   // result register
   logic       out_valid_ff;
   result_type out_ff;
   result_type parse_result;

   logic advance;

   // input word moves on when the result register is empty or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         arg_limit_ff <= ARG_LIMIT_RST;
         max_bulk_ff  <= MAX_BULK_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ARG_LIMIT:    arg_limit_ff <= csr_wdata[LIMIT_BITS-1:0];
            CSR_MAX_BULK_LEN: max_bulk_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff   <= req_op;
         in_byte_ff <= req_data_byte;
      end
   end

   rcsp_parser #(
      .MAX_ARGS (MAX_ARGS),
      .LEN_BITS (LEN_BITS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .op           (in_op_ff),
      .data_byte    (in_byte_ff),
      .arg_limit    (arg_limit_ff),
      .max_bulk_len (max_bulk_ff),
      .result       (parse_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= parse_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_payload_valid = out_ff.payload_valid;
   assign rsp_payload_byte  = out_ff.payload_byte;
   assign rsp_arg_index     = out_ff.arg_index;
   assign rsp_arg_done      = out_ff.arg_done;
   assign rsp_arg_length    = out_ff.arg_length;
   assign rsp_cmd_done      = out_ff.cmd_done;
   assign rsp_arg_count     = out_ff.arg_count;
   assign rsp_fault         = out_ff.fault;

endmodule

@@ src/rcsp_checker.sv @@
`include "resp_command_stream_parser_macros.svh"

module rcsp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_payload_valid,
   input logic [7:0]                          rsp_payload_byte,
   input logic                                rsp_arg_done,
   input logic                                rsp_cmd_done,
   input logic [rcsp_pkg::LIMIT_BITS-1:0]     rsp_arg_count,
   input logic                                rsp_fault
);

   // a faulted word carries nothing else
   `RCSP_ASSERT_IMP(a_fault_clean, clock, reset, rsp_valid && rsp_fault, !rsp_payload_valid && !rsp_arg_done && !rsp_cmd_done)

   // end of command only on an end of argument, with a real count
   `RCSP_ASSERT_IMP(a_cmd_on_arg, clock, reset, rsp_valid && rsp_cmd_done, rsp_arg_done && rsp_arg_count != '0)

   // content and argument close never share a word
   `RCSP_ASSERT_IMP(a_payload_not_done, clock, reset, rsp_valid && rsp_payload_valid, !rsp_arg_done)

   // stalled result word holds
   `RCSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_fault) && $stable(rsp_payload_byte))

endmodule

bind resp_command_stream_parser rcsp_checker u_rcsp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_payload_valid (rsp_payload_valid),
   .rsp_payload_byte  (rsp_payload_byte),
   .rsp_arg_done      (rsp_arg_done),
   .rsp_cmd_done      (rsp_cmd_done),
   .rsp_arg_count     (rsp_arg_count),
   .rsp_fault         (rsp_fault)
);

@@ test/testbench.sv @@
module testbench;
   import rcsp_pkg::*;

   // generous bound on the whole run, far above the slowest legal run
   localparam int CYCLE_LIMIT = 400000;
   localparam longint unsigned ACC_TOP = (64'd1 << LEN_BITS_DEF) - 1;

   // one request word as queued for the driver
   typedef struct {
      logic       op;
      logic [7:0] data;
   } req_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_op = 1'b0;
   logic [7:0]            req_data_byte = 8'h00;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_payload_valid;
   logic [7:0]            rsp_payload_byte;
   logic [INDEX_BITS-1:0] rsp_arg_index;
   logic                  rsp_arg_done;
   logic [BULK_BITS-1:0]  rsp_arg_length;
   logic                  rsp_cmd_done;
   logic [LIMIT_BITS-1:0] rsp_arg_count;
   logic                  rsp_fault;

   logic                  csr_wr_en = 1'b0;
   csr_index_type         csr_index = CSR_ARG_LIMIT;
   logic [BULK_BITS-1:0]  csr_wdata = '0;

   // words waiting to be sent, and parser results still to arrive
   req_word_type          words_to_send[$];
   result_type            results_due[$];

   // shadow copy of the registers
   logic [LIMIT_BITS-1:0] cfg_arg_limit = ARG_LIMIT_RST;
   logic [BULK_BITS-1:0]  cfg_max_bulk = MAX_BULK_RST;

   // shadow copy of the parse state, at its reset values
   phase_type             sh_phase = PH_HDR_PREFIX;
   logic                  sh_prev_cr = 1'b0;
   logic [BULK_BITS-1:0]  sh_acc = '0;
   logic                  sh_negative = 1'b0;
   logic                  sh_started = 1'b0;
   logic                  sh_ended = 1'b0;
   logic [LIMIT_BITS-1:0] sh_args_want = '0;
   logic [LIMIT_BITS-1:0] sh_args_seen = '0;
   logic [BULK_BITS-1:0]  sh_left = '0;
   logic [BULK_BITS-1:0]  sh_length = '0;

   int                    cycles = 0;
   int                    errors = 0;

   // sender burst and gap counters
   int                    burst_left = 1;
   int                    gap_left = 0;

   // receiver stall pattern
   logic [15:0]           ready_pattern = '1;
   logic [3:0]            ready_pos = '0;

   resp_command_stream_parser dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_arg_index     (rsp_arg_index),
      .rsp_arg_done      (rsp_arg_done),
      .rsp_arg_length    (rsp_arg_length),
      .rsp_cmd_done      (rsp_cmd_done),
      .rsp_arg_count     (rsp_arg_count),
      .rsp_fault         (rsp_fault),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // parser prediction
   // ---------------------------------------------------------------

   // argument count limit actually in force
   function automatic int eff_arg_limit();
      return (cfg_arg_limit < MAX_ARGS_DEF) ? int'(cfg_arg_limit) : int'(MAX_ARGS_DEF);
   endfunction

   function automatic void clear_number_state();
      sh_prev_cr  = 1'b0;
      sh_acc      = '0;
      sh_negative = 1'b0;
      sh_started  = 1'b0;
      sh_ended    = 1'b0;
   endfunction

   function automatic void clear_parse_state();
      sh_phase = PH_HDR_PREFIX;
      clear_number_state();
      sh_args_want = '0;
      sh_args_seen = '0;
      sh_left      = '0;
      sh_length    = '0;
   endfunction

   // one non-lf byte of a number line; 0 when the accumulator saturates
   function automatic bit number_byte(input logic [7:0] b);
      longint unsigned nxt;
      if (sh_ended)
         return 1'b1;
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         nxt = 64'(sh_acc) * 64'd10 + 64'(b - CHAR_ZERO);
         sh_started = 1'b1;
         if (nxt > ACC_TOP) begin
            sh_acc = '1;
            return 1'b0;
         end
         sh_acc = nxt[BULK_BITS-1:0];
         return 1'b1;
      end
      if (!sh_started) begin
         // leading white space is skipped, then an optional sign
         if (b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR))
            return 1'b1;
         if (b == CHAR_PLUS || b == CHAR_MINUS) begin
            sh_started  = 1'b1;
            sh_negative = (b == CHAR_MINUS);
            return 1'b1;
         end
      end
      // anything else ends the number, rest of the line ignored
      sh_ended = 1'b1;
      return 1'b1;
   endfunction

   // expected result word for one accepted request word
   function automatic result_type predict_parse(input logic op, input logic [7:0] b);
      result_type r;
      logic       flt;
      logic       bad_sign;
      r   = '0;
      flt = 1'b0;
      if (op) begin
         clear_parse_state();
      end else if (sh_phase == PH_ERROR) begin
         flt = 1'b1;
      end else begin
         r.arg_index = sh_args_seen[INDEX_BITS-1:0];
         case (sh_phase)
            PH_HDR_PREFIX: begin
               if (b != CHAR_STAR) begin
                  flt = 1'b1;
               end else begin
                  clear_number_state();
                  sh_phase = PH_HDR_LINE;
               end
            end
            PH_LEN_PREFIX: begin
               if (b != CHAR_DOLLAR) begin
                  flt = 1'b1;
               end else begin
                  clear_number_state();
                  sh_phase = PH_LEN_LINE;
               end
            end
            PH_HDR_LINE, PH_LEN_LINE: begin
               if (b == CHAR_LF) begin
                  // minus zero is accepted, any other negative value is not
                  bad_sign = sh_negative && (sh_acc != 0);
                  if (!sh_prev_cr) begin
                     flt = 1'b1;
                  end else if (sh_phase == PH_HDR_LINE) begin
                     if (bad_sign || sh_acc == 0 || sh_acc > eff_arg_limit()) begin
                        flt = 1'b1;
                     end else begin
                        sh_args_want = sh_acc[LIMIT_BITS-1:0];
                        sh_args_seen = '0;
                        sh_phase     = PH_LEN_PREFIX;
                     end
                  end else if (bad_sign || sh_acc > cfg_max_bulk) begin
                     flt = 1'b1;
                  end else begin
                     sh_length = sh_acc;
                     sh_left   = sh_acc;
                     if (sh_acc == 0)
                        sh_phase = PH_DATA_CR;
                     else
                        sh_phase = PH_DATA;
                  end
               end else begin
                  sh_prev_cr = (b == CHAR_CR);
                  if (!number_byte(b))
                     flt = 1'b1;
               end
            end
            PH_DATA: begin
               r.payload_valid = 1'b1;
               r.payload_byte  = b;
               if (sh_left != 0)
                  sh_left = sh_left - 1'b1;
               if (sh_left == 0)
                  sh_phase = PH_DATA_CR;
            end
            PH_DATA_CR: begin
               if (b != CHAR_CR)
                  flt = 1'b1;
               else
                  sh_phase = PH_DATA_LF;
            end
            default: begin
               // closing lf of an argument
               if (b != CHAR_LF) begin
                  flt = 1'b1;
               end else begin
                  r.arg_done   = 1'b1;
                  r.arg_length = sh_length;
                  sh_args_seen = sh_args_seen + 1'b1;
                  if (sh_args_seen >= sh_args_want) begin
                     r.cmd_done  = 1'b1;
                     r.arg_count = sh_args_want;
                     clear_parse_state();
                  end else begin
                     sh_phase = PH_LEN_PREFIX;
                  end
               end
            end
         endcase
         // a fault blanks every other field and sticks until a restart
         if (flt) begin
            sh_phase = PH_ERROR;
            r        = '0;
         end
      end
      r.fault = flt;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // mismatch reporting
   // ---------------------------------------------------------------

   task automatic note_mismatch(input string msg);
      errors++;
      if (errors <= 40)
         $display("mismatch, cycle %0d: %s", cycles, msg);
   endtask

   task automatic check_field(input string name, input longint unsigned got,
                              input longint unsigned want);
      if (got != want)
         note_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // ---------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------

   task automatic send_word(input logic op, input logic [7:0] data);
      req_word_type w;
      w.op   = op;
      w.data = data;
      words_to_send.push_back(w);
   endtask

   // restart word, its data byte is ignored
   task automatic send_restart();
      send_word(1'b1, 8'($urandom));
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_word(1'b0, s[i]);
   endtask

   task automatic send_line(input string s);
      send_text(s);
      send_word(1'b0, CHAR_CR);
      send_word(1'b0, CHAR_LF);
   endtask

   // number line with random white space, sign, leading zeros and trailing junk
   task automatic send_number_line(input longint unsigned value, input bit may_omit);
      logic [7:0] b;
      bit         omit;
      omit = may_omit && (value == 0) && ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            b = 8'($urandom_range(9, 13));
            if (b == CHAR_LF)
               b = CHAR_SPACE;
            send_word(1'b0, b);
         end
      end
      case ($urandom_range(0, 5))
         0: send_word(1'b0, CHAR_PLUS);
         1: if (value == 0) send_word(1'b0, CHAR_MINUS);
         default: ;
      endcase
      if (!omit) begin
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) send_word(1'b0, CHAR_ZERO);
         send_text($sformatf("%0d", value));
      end
      if ($urandom_range(0, 3) == 0) begin
         b = 8'($urandom);
         if ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_LF ||
             b == CHAR_PLUS || b == CHAR_MINUS)
            b = "x";
         send_word(1'b0, b);
         repeat ($urandom_range(0, 3)) send_word(1'b0, 8'($urandom_range("a", "z")));
      end
      send_word(1'b0, CHAR_CR);
      send_word(1'b0, CHAR_LF);
   endtask

   // well-formed command, every argument up to max_len bytes of random content
   task automatic send_command(input int n, input int max_len);
      int len;
      send_word(1'b0, CHAR_STAR);
      send_number_line(n, 1'b0);
      repeat (n) begin
         len = $urandom_range(0, max_len);
         send_word(1'b0, CHAR_DOLLAR);
         send_number_line(len, 1'b1);
         repeat (len) send_word(1'b0, 8'($urandom));
         send_word(1'b0, CHAR_CR);
         send_word(1'b0, CHAR_LF);
      end
   endtask

   // command sized to fit the current limits, now and then right at them
   task automatic send_good_command();
      int lim;
      int n;
      int max_len;
      lim = eff_arg_limit();
      n   = $urandom_range(1, (lim < 4) ? lim : 4);
      if (lim <= 8 && $urandom_range(0, 15) == 0)
         n = lim;
      max_len = (cfg_max_bulk < 6) ? int'(cfg_max_bulk) : 6;
      if (cfg_max_bulk <= 24 && $urandom_range(0, 7) == 0)
         max_len = int'(cfg_max_bulk);
      send_command(n, max_len);
   endtask

   // broken or interrupted command, always followed by a restart
   task automatic send_broken();
      int mark;
      int idx;
      case ($urandom_range(0, 3))
         0: begin
            // one byte of a good command replaced, possibly cut short there
            mark = words_to_send.size();
            send_good_command();
            idx = $urandom_range(mark, words_to_send.size() - 1);
            words_to_send[idx].data = 8'($urandom);
            if ($urandom_range(0, 1) == 1)
               while (words_to_send.size() > idx + 1)
                  void'(words_to_send.pop_back());
         end
         1: begin
            // count just above the limit
            send_word(1'b0, CHAR_STAR);
            send_number_line(eff_arg_limit() + $urandom_range(1, 3), 1'b0);
         end
         2: begin
            // length just above the largest allowed
            send_word(1'b0, CHAR_STAR);
            send_number_line(1, 1'b0);
            send_word(1'b0, CHAR_DOLLAR);
            send_number_line(cfg_max_bulk + $urandom_range(1, 5), 1'b0);
         end
         default: begin
            // largest allowed length, interrupted part way through the data
            send_word(1'b0, CHAR_STAR);
            send_number_line(1, 1'b0);
            send_word(1'b0, CHAR_DOLLAR);
            send_number_line(cfg_max_bulk, 1'b1);
            repeat ($urandom_range(0, 3)) send_word(1'b0, 8'($urandom));
         end
      endcase
      repeat ($urandom_range(0, 3)) send_word(1'b0, 8'($urandom));
      send_restart();
   endtask

   // raw noise, including stray restarts
   task automatic send_noise();
      repeat ($urandom_range(1, 8))
         send_word($urandom_range(0, 7) == 0, 8'($urandom));
      send_restart();
   endtask

   task automatic random_phase(input int budget);
      int goal;
      goal = words_to_send.size() + budget;
      while (words_to_send.size() < goal) begin
         case ($urandom_range(0, 19))
            0, 1, 2: send_broken();
            3:       send_noise();
            default: send_good_command();
         endcase
      end
   endtask

   // hand-picked words, run with the reset register values
   task automatic send_directed();
      send_restart();
      // shortest command, a single empty argument
      send_line("*1");
      send_line("$0");
      send_line("");
      // white space, sign and junk in number lines; an lf byte inside the payload
      send_line("* +2zz");
      send_line("$ 3junk");
      send_word(1'b0, 8'hFF);
      send_word(1'b0, 8'h00);
      send_word(1'b0, CHAR_LF);
      send_line("");
      send_line("$-0");
      send_line("");
      // wrong header prefix, then a word in the error phase
      send_text("X*");
      send_restart();
      // lf without cr
      send_text("*1");
      send_word(1'b0, CHAR_LF);
      send_restart();
      // accumulator overflow on the header
      send_text("*99999999999");
      send_restart();
      // zero, negative, above the limit and missing counts
      send_line("*0");
      send_restart();
      send_line("*-1");
      send_restart();
      send_line("*65");
      send_restart();
      send_line("* ");
      send_restart();
      // wrong length prefix
      send_line("*1");
      send_text("#");
      send_restart();
      // negative, too long and overflowing lengths
      send_line("*1");
      send_line("$-2");
      send_restart();
      send_line("*1");
      send_line("$1073741825");
      send_restart();
      send_line("*1");
      send_line("$2147483648");
      send_restart();
      // no cr after the data, then cr without lf
      send_line("*1");
      send_line("$1");
      send_text("AB");
      send_restart();
      send_line("*1");
      send_line("$0");
      send_word(1'b0, CHAR_CR);
      send_text("x");
      send_restart();
      // missing length counts as zero
      send_line("*1");
      send_line("$\t");
      send_line("");
   endtask

   // ---------------------------------------------------------------
   // register writes and sequencing
   // ---------------------------------------------------------------

   task automatic write_csr(input csr_index_type idx, input logic [BULK_BITS-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_ARG_LIMIT)
         cfg_arg_limit = value[LIMIT_BITS-1:0];
      else
         cfg_max_bulk = value;
   endtask

   // nothing queued, nothing on the request port, nothing still to arrive
   task automatic wait_drained();
      while (words_to_send.size() != 0 || req_valid || results_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(input int lim, input int bulk, input int budget);
      wait_drained();
      // upper bits of the arg limit write are junk and must be dropped
      write_csr(CSR_ARG_LIMIT, {24'($urandom), 7'(lim)});
      write_csr(CSR_MAX_BULK_LEN, 31'(bulk));
      @(negedge clock);
      random_phase(budget);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // reset register values first
      send_directed();
      random_phase(150);
      // smallest limits
      run_phase(1, 0, 100);
      // largest limits, with one command carrying the most arguments
      run_phase(64, 1 << 30, 100);
      send_command(64, 0);
      run_phase(3, 5, 100);
      run_phase($urandom_range(1, 64), $urandom_range(0, 40), 100);
      run_phase(2, 24, 100);
      wait_drained();
      // a few more cycles to catch any stray result word
      repeat (8) @(negedge clock);
      if (results_due.size() != 0)
         note_mismatch("result words still expected at the end");
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------
   // driver: bursts of random length with random gaps between them
   // ---------------------------------------------------------------

   always @(posedge clock) begin : driver
      req_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // word accepted at this edge: predict its result
         if (req_valid && req_ready)
            results_due.push_back(predict_parse(req_op, req_data_byte));
         // the port is free: idle, present the next word, or run dry
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (words_to_send.size() != 0) begin
               w = words_to_send.pop_front();
               req_valid     <= 1'b1;
               req_op        <= w.op;
               req_data_byte <= w.data;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // receiver: stall pattern renewed after each pass through its 16 bits, sometimes no stalls
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ready_pattern[ready_pos];
         ready_pos <= ready_pos + 1'b1;
         if (ready_pos == 4'hF) begin
            case ($urandom_range(0, 3))
               0:       ready_pattern <= '1;
               1:       ready_pattern <= 16'($urandom);
               default: ready_pattern <= 16'($urandom) | 16'($urandom);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: every result word against the oldest expectation
   // ---------------------------------------------------------------

   always @(posedge clock) begin : monitor
      result_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            note_mismatch("result word with none expected");
         end else begin
            due = results_due.pop_front();
            check_field("payload_valid", rsp_payload_valid, due.payload_valid);
            check_field("payload_byte", rsp_payload_byte, due.payload_byte);
            check_field("arg_index", rsp_arg_index, due.arg_index);
            check_field("arg_done", rsp_arg_done, due.arg_done);
            check_field("arg_length", rsp_arg_length, due.arg_length);
            check_field("cmd_done", rsp_cmd_done, due.cmd_done);
            check_field("arg_count", rsp_arg_count, due.arg_count);
            check_field("fault", rsp_fault, due.fault);
         end
      end
   end

   // watchdog on the cycle count
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

endmodule
